FILE: rtl/icd_pkg.sv
// ----------------------------------------------------------------------------
// icd_pkg
// Shared constants, types and helpers for the index chain cycle detector.
// ----------------------------------------------------------------------------
package icd_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int WORD_WIDTH  = 16;
  localparam int IN_WIDTH    = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic load_en;
    logic walk_start;
    logic step_read;
    logic step_advance;
    logic latch_verdict;
    logic out_push;
  } icd_cmd_t;

  typedef struct packed {
    logic last_pos;
    logic stop;
    logic out_free;
  } icd_sts_t;

  function automatic word_t to_word(input logic signed [IN_WIDTH-1:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return word_t'(ext[WORD_WIDTH-1:0]);
  endfunction

endpackage

FILE: rtl/icd_ctrl.sv
// ----------------------------------------------------------------------------
// icd_ctrl
// Controller: sequences table load, walk steps and verdict delivery.
// ----------------------------------------------------------------------------
module icd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  icd_pkg::icd_sts_t sts,
  output icd_pkg::icd_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load_en = in_valid;
        if (in_valid && sts.last_pos) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        cmd.step_read = 1'b1;
        state_nxt     = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.stop) begin
          cmd.latch_verdict = 1'b1;
          state_nxt         = ST_HOLD;
        end else begin
          cmd.step_advance = 1'b1;
          state_nxt        = ST_READ;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.out_push = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/icd_datapath.sv
// ----------------------------------------------------------------------------
// icd_datapath
// Datapath: table memory, visited marks, walk index and output register.
// ----------------------------------------------------------------------------
module icd_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [icd_pkg::IN_WIDTH-1:0]   in_element_value,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_is_cyclic,
  input  icd_pkg::icd_cmd_t                     cmd,
  output icd_pkg::icd_sts_t                     sts
);

  icd_pkg::word_t                     table_mem [icd_pkg::TABLE_DEPTH];
  icd_pkg::word_t                     rd_data_r;
  icd_pkg::idx_t                      load_pos_r;
  icd_pkg::idx_t                      walk_idx_r;
  logic [icd_pkg::TABLE_DEPTH-1:0]    visited_r;
  logic                               verdict_r;
  logic                               out_valid_r;
  logic                               out_cyc_r;
  logic                               in_range;
  logic                               seen;
  icd_pkg::idx_t                      next_idx;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      table_mem[load_pos_r] <= icd_pkg::to_word(in_element_value);
    end
    if (cmd.step_read) begin
      rd_data_r <= table_mem[walk_idx_r];
    end
  end

  assign in_range = !rd_data_r[icd_pkg::WORD_WIDTH-1] &&
                    (32'($unsigned(rd_data_r)) < 32'(icd_pkg::TABLE_DEPTH));
  assign next_idx = rd_data_r[icd_pkg::IDX_W-1:0];
  assign seen     = visited_r[next_idx];

  assign sts.last_pos = (load_pos_r == icd_pkg::idx_t'(icd_pkg::TABLE_DEPTH - 1));
  assign sts.stop     = !in_range || seen;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r  <= '0;
      walk_idx_r  <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        load_pos_r <= sts.last_pos ? '0 : load_pos_r + icd_pkg::idx_t'(1);
      end
      if (cmd.walk_start) begin
        walk_idx_r <= '0;
        visited_r  <= '0;
      end else if (cmd.step_read) begin
        visited_r[walk_idx_r] <= 1'b1;
      end else if (cmd.step_advance) begin
        walk_idx_r <= next_idx;
      end
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_verdict) begin
      verdict_r <= in_range;
    end
    if (cmd.out_push) begin
      out_cyc_r <= verdict_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_cyclic = out_cyc_r;

endmodule

FILE: rtl/index_chain_cycle_detector_unit.sv
// ----------------------------------------------------------------------------
// index_chain_cycle_detector_unit
// Loads a table of signed index words and reports whether the chain from
// index 0 revisits an element.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while in_ready is high, into table positions
// 0 to TABLE_DEPTH-1. Loading the last word starts a walk from index 0. Each
// step is a table memory read followed by a range and visited check on the
// word read, and a walk reads at most TABLE_DEPTH entries. After the walk the
// verdict is latched and moved to the output register. in_ready is low during
// the walk. One verdict per table appears on out_is_cyclic: 1 when the walk
// reaches a visited element, 0 when a word names an index outside the table
// (negative words included). The verdict sits in an output register, so
// loading of the next table resumes while it waits to be taken; a walk that
// ends while the previous verdict is still untaken keeps in_ready low until
// that verdict is taken.
module index_chain_cycle_detector_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [icd_pkg::IN_WIDTH-1:0] in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_is_cyclic
);

  icd_pkg::icd_cmd_t cmd;
  icd_pkg::icd_sts_t sts;

  icd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  icd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_element_value (in_element_value),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_is_cyclic    (out_is_cyclic),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
